// ----- hdl/skt_pkg.sv -----
// Package for the sorted key table: sizes, codes, entry, control, search and response types.
// Used by the channel interfaces, the cell, the chain and the top level.
package skt_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int OP_W   = 2;
   localparam int KEY_W  = 32;
   localparam int DAY_W  = 32;
   localparam int FLAG_W = 6;
   localparam int STAT_W = 3;
   localparam int POS_W  = 7;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [DAY_W-1:0] start_day;
      logic signed [DAY_W-1:0] end_day;
      logic [FLAG_W-1:0]       flag_bit;
   } entry_type;

   typedef struct packed {
      logic compare;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] pos;
      entry_type        entry;
   } search_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [POS_W-1:0]        position;
      logic signed [DAY_W-1:0] found_start_day;
      logic signed [DAY_W-1:0] found_end_day;
      logic [FLAG_W-1:0]       found_flag_bit;
      logic [POS_W-1:0]        entry_count;
   } rsp_type;

endpackage

// ----- hdl/skt_req_if.sv -----
// Request channel of the sorted key table: valid, ready and one request item.
// Depends on skt_pkg for field widths.
interface skt_req_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::OP_W-1:0]         operation;
   logic signed [skt_pkg::KEY_W-1:0] key;
   logic signed [skt_pkg::DAY_W-1:0] start_day;
   logic signed [skt_pkg::DAY_W-1:0] end_day;
   logic [skt_pkg::FLAG_W-1:0]       flag_bit;

   modport source (output valid, operation, key, start_day, end_day, flag_bit, input ready);
   modport sink (input valid, operation, key, start_day, end_day, flag_bit, output ready);
endinterface

// ----- hdl/skt_rsp_if.sv -----
// Response channel of the sorted key table: valid, ready and one result item.
// Depends on skt_pkg for field widths.
interface skt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::STAT_W-1:0]       status;
   logic [skt_pkg::POS_W-1:0]        position;
   logic signed [skt_pkg::DAY_W-1:0] found_start_day;
   logic signed [skt_pkg::DAY_W-1:0] found_end_day;
   logic [skt_pkg::FLAG_W-1:0]       found_flag_bit;
   logic [skt_pkg::POS_W-1:0]        entry_count;

   modport source (output valid, status, position, found_start_day, found_end_day,
                   found_flag_bit, entry_count, input ready);
   modport sink (input valid, status, position, found_start_day, found_end_day,
                 found_flag_bit, entry_count, output ready);
endinterface

// ----- hdl/skt_cell.sv -----
// One table slot: holds an entry, compares it with the search key and
// takes its left neighbor's entry or the new entry on insert. Depends on skt_pkg.
module skt_cell (
   input  logic                             clock,
   input  skt_pkg::cell_ctrl_type           ctrl,
   input  logic                             occupied,
   input  logic signed [skt_pkg::KEY_W-1:0] search_key,
   input  skt_pkg::entry_type               new_entry,
   input  skt_pkg::entry_type               left_entry,
   input  logic                             left_lt,
   output skt_pkg::entry_type               entry,
   output logic                             lt,
   output logic                             eq
);

   skt_pkg::entry_type entry_ff, entry_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.compare) begin
         lt_in = occupied && (entry_ff.key < search_key);
         eq_in = occupied && (entry_ff.key == search_key);
      end
      if (ctrl.write) begin
         if (!left_lt) begin
            entry_in = left_entry;
         end else if (!lt_ff) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ----- hdl/skt_chain.sv -----
// Row of table cells linked left to right, plus the one-hot reduction that
// turns their compare flags into hit, position and matched entry. Depends on skt_pkg, skt_cell.
module skt_chain (
   input  logic                             clock,
   input  skt_pkg::cell_ctrl_type           ctrl,
   input  logic [skt_pkg::CNT_W-1:0]        count,
   input  logic signed [skt_pkg::KEY_W-1:0] search_key,
   input  skt_pkg::entry_type               new_entry,
   output skt_pkg::search_type              result
);

   skt_pkg::entry_type         entries [skt_pkg::DEPTH];
   logic [skt_pkg::DEPTH-1:0]  lt;
   logic [skt_pkg::DEPTH-1:0]  eq;
   logic [skt_pkg::DEPTH-1:0]  left_lt;
   logic [skt_pkg::DEPTH-1:0]  boundary;

   genvar i;
   generate
      for (i = 0; i < skt_pkg::DEPTH; i++) begin : g_cell
         skt_pkg::entry_type left_entry;
         if (i == 0) begin : g_first
            assign left_lt[i] = 1'b1;
            assign left_entry = new_entry;
         end else begin : g_rest
            assign left_lt[i] = lt[i-1];
            assign left_entry = entries[i-1];
         end
         assign boundary[i] = left_lt[i] & ~lt[i];

         skt_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (count > skt_pkg::CNT_W'(i)),
            .search_key (search_key),
            .new_entry  (new_entry),
            .left_entry (left_entry),
            .left_lt    (left_lt[i]),
            .entry      (entries[i]),
            .lt         (lt[i]),
            .eq         (eq[i])
         );
      end
   endgenerate

   always_comb begin
      logic [skt_pkg::CNT_W-1:0] pos_or;
      skt_pkg::entry_type        hit_or;
      pos_or = '0;
      hit_or = '0;
      for (int k = 0; k < skt_pkg::DEPTH; k++) begin
         if (boundary[k]) begin
            pos_or = pos_or | skt_pkg::CNT_W'(k);
         end
         if (eq[k]) begin
            hit_or = hit_or | entries[k];
         end
      end
      result.hit   = |eq;
      result.pos   = (|boundary) ? pos_or : count;
      result.entry = hit_or;
   end

endmodule

// ----- hdl/sorted_key_table_top.sv -----
// Sorted key table top level: request/response handshake, sequencer and
// entry count around the cell chain. Depends on skt_pkg, skt_req_if, skt_rsp_if, skt_chain.
// An accepted request item moves through compare, reduce and respond states in order.
// One item at a time; the next request is taken the cycle after the result is taken.
// Reset clears the sequencer and the entry count; table slots keep their contents.
module sorted_key_table_top (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_chan,
   skt_rsp_if.source rsp_chan
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_RED  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [skt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [skt_pkg::OP_W-1:0]  op_ff, op_in;
   logic signed [skt_pkg::KEY_W-1:0] key_ff, key_in;
   skt_pkg::entry_type        new_ff, new_in;
   skt_pkg::rsp_type          rsp_ff, rsp_in;

   skt_pkg::cell_ctrl_type    ctrl;
   skt_pkg::search_type       result;
   logic                      full;
   logic                      req_take;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == skt_pkg::CNT_W'(skt_pkg::DEPTH));

   skt_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .count      (count_ff),
      .search_key (key_ff),
      .new_entry  (new_ff),
      .result     (result)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      new_in       = new_ff;
      rsp_in       = rsp_ff;
      ctrl.compare = 1'b0;
      ctrl.write   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in              = req_chan.operation;
               key_in             = req_chan.key;
               new_in.key         = req_chan.key;
               new_in.start_day   = req_chan.start_day;
               new_in.end_day     = req_chan.end_day;
               new_in.flag_bit    = req_chan.flag_bit;
               state_in           = S_CMP;
            end
         end
         S_CMP: begin
            ctrl.compare = 1'b1;
            state_in     = S_RED;
         end
         S_RED: begin
            rsp_in                 = '0;
            rsp_in.position        = skt_pkg::POS_W'(result.pos);
            if (op_ff == skt_pkg::OP_CLEAR) begin
               count_in        = '0;
               rsp_in.status   = skt_pkg::ST_INSERTED;
               rsp_in.position = '0;
            end else if (op_ff == skt_pkg::OP_INSERT) begin
               if (full) begin
                  rsp_in.status = skt_pkg::ST_FULL;
               end else if (result.hit) begin
                  rsp_in.status          = skt_pkg::ST_DUPLICATE;
                  rsp_in.found_start_day = result.entry.start_day;
                  rsp_in.found_end_day   = result.entry.end_day;
                  rsp_in.found_flag_bit  = result.entry.flag_bit;
               end else begin
                  rsp_in.status = skt_pkg::ST_INSERTED;
                  ctrl.write    = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end else begin
               if (result.hit) begin
                  rsp_in.status          = skt_pkg::ST_FOUND;
                  rsp_in.found_start_day = result.entry.start_day;
                  rsp_in.found_end_day   = result.entry.end_day;
                  rsp_in.found_flag_bit  = result.entry.flag_bit;
               end else begin
                  rsp_in.status = skt_pkg::ST_NOT_FOUND;
               end
            end
            rsp_in.entry_count = skt_pkg::POS_W'(count_in);
            state_in           = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid           = (state_ff == S_OUT);
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.position        = rsp_ff.position;
   assign rsp_chan.found_start_day = rsp_ff.found_start_day;
   assign rsp_chan.found_end_day   = rsp_ff.found_end_day;
   assign rsp_chan.found_flag_bit  = rsp_ff.found_flag_bit;
   assign rsp_chan.entry_count     = rsp_ff.entry_count;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
      else $error("entry count above table depth");

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.write |-> !full && !result.hit)
      else $error("insert write into full table or over existing key");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      ctrl.write |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance entry count");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_CMP)
      else $error("accepted item did not start compare");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == skt_pkg::ST_NOT_FOUND
      |-> rsp_chan.found_start_day == 0 && rsp_chan.found_end_day == 0
          && rsp_chan.found_flag_bit == 0)
      else $error("miss result carries entry data");

endmodule

// ----- tb/sorted_key_table_top_test.sv -----
// Testbench for sorted_key_table_top: lookups, inserts, clears and the spare operation code against a table model.
// Checks each result item field by field, in order, with random idling on both channels in all but the last phase.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and sorted_key_table_top.
module sorted_key_table_top_test;
   import skt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PRINT_LIMIT    = 100;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam logic signed [KEY_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] S32_MAX = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   skt_req_if req_bus();
   skt_rsp_if rsp_bus();

   sorted_key_table_top uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   entry_type table_slots [DEPTH];
   int        table_count;
   rsp_type   predicted_rsps [$];
   int        error_count;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        idle_cycles;

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Search the sorted table, apply the operation and return the result item.
   function automatic rsp_type apply_table_op(
      input logic [OP_W-1:0]         op,
      input logic signed [KEY_W-1:0] key,
      input logic signed [DAY_W-1:0] sday,
      input logic signed [DAY_W-1:0] eday,
      input logic [FLAG_W-1:0]       fbit
   );
      rsp_type rsp;
      int      lo;
      int      hi;
      int      mid;
      int      pos;
      bit      hit;
      rsp = '0;
      lo  = 0;
      hi  = table_count;
      pos = 0;
      hit = 1'b0;
      if (op == OP_CLEAR) begin
         table_count = 0;
         rsp.status  = ST_INSERTED;
      end else begin
         while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (key == table_slots[mid].key) begin
               hit = 1'b1;
               pos = mid;
            end else if ($signed(key) > $signed(table_slots[mid].key)) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         if (!hit)
            pos = lo;
         rsp.position = POS_W'(pos);
         if (op == OP_INSERT) begin
            if (table_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else if (hit) begin
               rsp.status          = ST_DUPLICATE;
               rsp.found_start_day = table_slots[pos].start_day;
               rsp.found_end_day   = table_slots[pos].end_day;
               rsp.found_flag_bit  = table_slots[pos].flag_bit;
            end else begin
               for (int i = table_count; i > pos; i--)
                  table_slots[i] = table_slots[i-1];
               table_slots[pos] = '{key, sday, eday, fbit};
               table_count++;
               rsp.status = ST_INSERTED;
            end
         end else if (hit) begin
            rsp.status          = ST_FOUND;
            rsp.found_start_day = table_slots[pos].start_day;
            rsp.found_end_day   = table_slots[pos].end_day;
            rsp.found_flag_bit  = table_slots[pos].flag_bit;
         end else begin
            rsp.status = ST_NOT_FOUND;
         end
      end
      rsp.entry_count = POS_W'(table_count);
      return rsp;
   endfunction

   // Mix fresh keys with stored keys, their neighbors, extremes and a narrow band.
   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] k;
      k = $urandom;
      case ($urandom_range(9))
         4, 5: begin
            if (table_count > 0)
               k = table_slots[$urandom_range(table_count - 1)].key;
         end
         6: begin
            if (table_count > 0) begin
               k = table_slots[$urandom_range(table_count - 1)].key;
               k = $urandom_range(1) ? k + 1 : k - 1;
            end
         end
         7: begin
            case ($urandom_range(3))
               0: k = S32_MIN;
               1: k = S32_MAX;
               2: k = '0;
               default: k = '1;
            endcase
         end
         8, 9: begin
            k = $urandom_range(16);
            k = k - 8;
         end
         default: ;
      endcase
      return k;
   endfunction

   function automatic logic [FLAG_W-1:0] rand_flag();
      return FLAG_W'($urandom_range(63));
   endfunction

   task automatic send_table_op(
      input logic [OP_W-1:0]         op,
      input logic signed [KEY_W-1:0] key,
      input logic signed [DAY_W-1:0] sday,
      input logic signed [DAY_W-1:0] eday,
      input logic [FLAG_W-1:0]       fbit
   );
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.key       = key;
      req_bus.start_day = sday;
      req_bus.end_day   = eday;
      req_bus.flag_bit  = fbit;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted_rsps.push_back(apply_table_op(op, key, sday, eday, fbit));
   endtask

   task automatic test_empty_table();
      send_table_op(OP_LOOKUP, 32'sd0, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_SPARE, S32_MIN, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_CLEAR, 32'sd0, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_INSERT, 32'sd0, 32'sd7, 32'sd9, 6'd3);
   endtask

   task automatic test_field_extremes();
      send_table_op(OP_INSERT, S32_MAX, S32_MIN, S32_MAX, 6'd32);
      send_table_op(OP_INSERT, S32_MIN, S32_MAX, S32_MIN, 6'd0);
      send_table_op(OP_INSERT, -32'sd1, 32'sd0, -32'sd1, 6'h3f);
      send_table_op(OP_INSERT, 32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 6'd1);
      send_table_op(OP_LOOKUP, S32_MAX, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_LOOKUP, S32_MIN, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_LOOKUP, -32'sd1, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_LOOKUP, 32'sd0, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_LOOKUP, 32'sd1, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_LOOKUP, 32'sd5, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_SPARE, S32_MIN, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_SPARE, -32'sd5, 32'sd0, 32'sd0, 6'd0);
      send_table_op(OP_INSERT, 32'sd0, 32'sd100, 32'sd200, 6'd5);
      send_table_op(OP_INSERT, S32_MAX, 32'sd1, 32'sd2, 6'd4);
      send_table_op(OP_CLEAR, S32_MAX, S32_MAX, S32_MAX, 6'h3f);
      send_table_op(OP_LOOKUP, 32'sd0, 32'sd0, 32'sd0, 6'd0);
   endtask

   task automatic test_full_table();
      send_table_op(OP_CLEAR, $urandom, $urandom, $urandom, rand_flag());
      while (table_count < DEPTH) begin
         if ($urandom_range(7) == 0)
            send_table_op(OP_LOOKUP, pick_key(), $urandom, $urandom, rand_flag());
         else if ($urandom_range(5) == 0)
            send_table_op(OP_INSERT, pick_key(), $urandom, $urandom, rand_flag());
         else
            send_table_op(OP_INSERT, $urandom, $urandom, $urandom, rand_flag());
      end
      send_table_op(OP_INSERT, table_slots[$urandom_range(DEPTH - 1)].key,
                    $urandom, $urandom, rand_flag());
      send_table_op(OP_INSERT, $urandom, $urandom, $urandom, rand_flag());
      send_table_op(OP_INSERT, S32_MIN, $urandom, $urandom, rand_flag());
      send_table_op(OP_INSERT, S32_MAX, $urandom, $urandom, rand_flag());
      repeat (4)
         send_table_op(OP_LOOKUP, pick_key(), $urandom, $urandom, rand_flag());
      send_table_op(OP_SPARE, pick_key(), $urandom, $urandom, rand_flag());
      send_table_op(OP_CLEAR, $urandom, $urandom, $urandom, rand_flag());
   endtask

   task automatic test_random_ops(input int count);
      logic [OP_W-1:0] op;
      int              pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 2)
            op = OP_CLEAR;
         else if (pick < 52)
            op = OP_INSERT;
         else if (pick < 92)
            op = OP_LOOKUP;
         else
            op = OP_SPARE;
         send_table_op(op, pick_key(), $urandom, $urandom, rand_flag());
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_rsps.size() == 0) begin
            report_mismatch("result item with none outstanding");
         end else begin
            exp = predicted_rsps.pop_front();
            if (rsp_bus.status !== exp.status)
               report_mismatch($sformatf("status: expected %0d, got %0d",
                                         exp.status, rsp_bus.status));
            if (rsp_bus.position !== exp.position)
               report_mismatch($sformatf("position: expected %0d, got %0d",
                                         exp.position, rsp_bus.position));
            if (rsp_bus.found_start_day !== exp.found_start_day)
               report_mismatch($sformatf("found_start_day: expected %0d, got %0d",
                                         exp.found_start_day, rsp_bus.found_start_day));
            if (rsp_bus.found_end_day !== exp.found_end_day)
               report_mismatch($sformatf("found_end_day: expected %0d, got %0d",
                                         exp.found_end_day, rsp_bus.found_end_day));
            if (rsp_bus.found_flag_bit !== exp.found_flag_bit)
               report_mismatch($sformatf("found_flag_bit: expected %0d, got %0d",
                                         exp.found_flag_bit, rsp_bus.found_flag_bit));
            if (rsp_bus.entry_count !== exp.entry_count)
               report_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                         exp.entry_count, rsp_bus.entry_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_LOOKUP;
      req_bus.key       = '0;
      req_bus.start_day = '0;
      req_bus.end_day   = '0;
      req_bus.flag_bit  = '0;
      rsp_bus.ready     = 1'b0;
      error_count       = 0;
      table_count       = 0;
      idle_cycles       = 0;
      send_idle_pct     = 35;
      recv_idle_pct     = 58;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_field_extremes();
      test_full_table();
      test_random_ops(55);

      send_idle_pct = 58;
      recv_idle_pct = 35;
      test_full_table();
      test_random_ops(55);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_table();
      test_random_ops(55);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sorted_key_table_top.f -----
hdl/skt_pkg.sv
hdl/skt_req_if.sv
hdl/skt_rsp_if.sv
hdl/skt_cell.sv
hdl/skt_chain.sv
hdl/sorted_key_table_top.sv
tb/sorted_key_table_top_test.sv
